// ===== rtl/core/indexed_list_engine_assert.svh =====
// ----------------------------------------------------------------------------
// indexed_list_engine assertion macros
// shared property forms for the checkers of the list engine
// ----------------------------------------------------------------------------
`ifndef INDEXED_LIST_ENGINE_ASSERT_SVH
`define INDEXED_LIST_ENGINE_ASSERT_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define ILE_ASSERT_IMP(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while arst_n is low
`define ILE_ASSERT_NXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/ile_pkg.sv =====
// ----------------------------------------------------------------------------
// ile_pkg
// types and constants shared by the indexed list engine
// ----------------------------------------------------------------------------
package ile_pkg;

	localparam int CMD_W      = 3;
	localparam int POS_W      = 4;
	localparam int DATA_W     = 32;
	localparam int CNT_OUT_W  = 5;
	localparam int S_TDATA_W  = 40;
	localparam int M_TDATA_W  = 48;

	typedef enum logic [CMD_W-1:0] {
		CMD_GET          = 3'd0,
		CMD_SET          = 3'd1,
		CMD_INSERT       = 3'd2,
		CMD_REMOVE_AT    = 3'd3,
		CMD_APPEND       = 3'd4,
		CMD_REMOVE_VALUE = 3'd5,
		CMD_INDEX_OF     = 3'd6,
		CMD_CLEAR        = 3'd7
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_RANGE    = 2'd1,
		ST_FULL     = 2'd2,
		ST_NOTFOUND = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		FSM_IDLE,
		FSM_START,
		FSM_GET_WAIT,
		FSM_SEARCH,
		FSM_SHIFT_DN,
		FSM_SHIFT_UP,
		FSM_INS_WRITE,
		FSM_FINISH
	} fsm_state_t;

	typedef struct packed {
		cmd_t              command;
		logic [POS_W-1:0]  position;
		logic [DATA_W-1:0] entry_value;
	} cmd_req_t;

	typedef struct packed {
		logic [DATA_W-1:0]    read_value;
		logic [POS_W-1:0]     found_position;
		logic                 found;
		logic [CNT_OUT_W-1:0] count;
		logic                 empty_res;
		status_t              status;
	} res_t;

endpackage

// ===== rtl/core/ile_ram.sv =====
// ----------------------------------------------------------------------------
// ile_ram
// generic simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module ile_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/core/ile_ctrl.sv =====
// ----------------------------------------------------------------------------
// ile_ctrl
// command sequencer: live count, scans and shifts over the entry ram
// ----------------------------------------------------------------------------
module ile_ctrl #(
	parameter int CAPACITY    = 16,
	parameter int VALUE_WIDTH = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cmd_valid,
	output logic                        cmd_ready,
	input  ile_pkg::cmd_req_t           req,
	output logic                        res_valid,
	input  logic                        res_ready,
	output ile_pkg::res_t               res,
	output logic                        we,
	output logic [$clog2(CAPACITY)-1:0] waddr,
	output logic [VALUE_WIDTH-1:0]      wdata,
	output logic [$clog2(CAPACITY)-1:0] raddr,
	input  logic [VALUE_WIDTH-1:0]      rdata
);

	import ile_pkg::*;

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int PW = (CW > POS_W) ? CW : POS_W;

	fsm_state_t             state_q, state_d;
	cmd_t                   cmd_q, cmd_d;
	logic [POS_W-1:0]       pos_q, pos_d;
	logic [VALUE_WIDTH-1:0] val_q, val_d;
	logic [CW-1:0]          cnt_q, cnt_d;
	logic [AW-1:0]          idx_q, idx_d;
	logic                   rv_s1, issue;
	logic [AW-1:0]          ridx_s1;
	logic [DATA_W-1:0]      rd_q, rd_d;
	logic [POS_W-1:0]       fpos_q, fpos_d;
	logic                   fnd_q, fnd_d;
	status_t                st_q, st_d;

	logic          inrange, full, idx_lt_cnt;
	logic [AW-1:0] pos_addr, cnt_m1;

	assign inrange    = PW'(pos_q) < PW'(cnt_q);
	assign full       = cnt_q == CW'(CAPACITY);
	assign idx_lt_cnt = CW'(idx_q) < cnt_q;
	assign pos_addr   = AW'(pos_q);
	assign cnt_m1     = AW'(cnt_q - CW'(1));

	always_comb begin
		state_d   = state_q;
		cmd_d     = cmd_q;
		pos_d     = pos_q;
		val_d     = val_q;
		cnt_d     = cnt_q;
		idx_d     = idx_q;
		rd_d      = rd_q;
		fpos_d    = fpos_q;
		fnd_d     = fnd_q;
		st_d      = st_q;
		issue     = 1'b0;
		raddr     = idx_q;
		we        = 1'b0;
		waddr     = '0;
		wdata     = rdata;
		cmd_ready = 1'b0;
		res_valid = 1'b0;
		unique case (state_q)
			FSM_IDLE: begin
				cmd_ready = 1'b1;
				if (cmd_valid) begin
					cmd_d   = req.command;
					pos_d   = req.position;
					val_d   = VALUE_WIDTH'(req.entry_value);
					state_d = FSM_START;
				end
			end
			FSM_START: begin
				rd_d    = '0;
				fpos_d  = '0;
				fnd_d   = 1'b0;
				st_d    = ST_OK;
				state_d = FSM_FINISH;
				unique case (cmd_q) inside
					CMD_GET: begin
						if (inrange) begin
							raddr   = pos_addr;
							state_d = FSM_GET_WAIT;
						end else begin
							st_d = ST_RANGE;
						end
					end
					CMD_SET: begin
						if (inrange) begin
							we    = 1'b1;
							waddr = pos_addr;
							wdata = val_q;
						end else begin
							st_d = ST_RANGE;
						end
					end
					CMD_INSERT: begin
						if (!inrange) begin
							st_d = ST_RANGE;
						end else if (full) begin
							st_d = ST_FULL;
						end else begin
							idx_d   = cnt_m1;
							state_d = FSM_SHIFT_UP;
						end
					end
					CMD_REMOVE_AT: begin
						if (!inrange) begin
							st_d = ST_RANGE;
						end else if (pos_addr == cnt_m1) begin
							cnt_d = cnt_q - CW'(1);
						end else begin
							idx_d   = pos_addr + AW'(1);
							state_d = FSM_SHIFT_DN;
						end
					end
					CMD_APPEND: begin
						if (full) begin
							st_d = ST_FULL;
						end else begin
							we    = 1'b1;
							waddr = AW'(cnt_q);
							wdata = val_q;
							cnt_d = cnt_q + CW'(1);
						end
					end
					CMD_REMOVE_VALUE, CMD_INDEX_OF: begin
						if (cnt_q == '0) begin
							st_d = ST_NOTFOUND;
						end else begin
							idx_d   = '0;
							state_d = FSM_SEARCH;
						end
					end
					CMD_CLEAR: begin
						cnt_d = '0;
					end
				endcase
			end
			FSM_GET_WAIT: begin
				rd_d    = DATA_W'(rdata);
				state_d = FSM_FINISH;
			end
			FSM_SEARCH: begin
				if (rv_s1 && rdata == val_q) begin
					fnd_d  = 1'b1;
					fpos_d = POS_W'(ridx_s1);
					if (cmd_q != CMD_REMOVE_VALUE) begin
						state_d = FSM_FINISH;
					end else if (ridx_s1 == cnt_m1) begin
						cnt_d   = cnt_q - CW'(1);
						state_d = FSM_FINISH;
					end else begin
						idx_d   = ridx_s1 + AW'(1);
						state_d = FSM_SHIFT_DN;
					end
				end else if (rv_s1 && ridx_s1 == cnt_m1) begin
					st_d    = ST_NOTFOUND;
					state_d = FSM_FINISH;
				end else if (idx_lt_cnt) begin
					issue = 1'b1;
					idx_d = idx_q + AW'(1);
				end
			end
			FSM_SHIFT_DN: begin
				// entry i+1 read last cycle lands in entry i
				if (rv_s1) begin
					we    = 1'b1;
					waddr = ridx_s1 - AW'(1);
				end
				if (rv_s1 && ridx_s1 == cnt_m1) begin
					cnt_d   = cnt_q - CW'(1);
					state_d = FSM_FINISH;
				end else if (idx_lt_cnt) begin
					issue = 1'b1;
					idx_d = idx_q + AW'(1);
				end
			end
			FSM_SHIFT_UP: begin
				// walk down from the top, entry i lands in entry i+1
				if (rv_s1) begin
					we    = 1'b1;
					waddr = ridx_s1 + AW'(1);
				end
				if (rv_s1 && ridx_s1 == pos_addr) begin
					state_d = FSM_INS_WRITE;
				end else if (idx_q >= pos_addr) begin
					issue = 1'b1;
					idx_d = idx_q - AW'(1);
				end
			end
			FSM_INS_WRITE: begin
				we      = 1'b1;
				waddr   = pos_addr;
				wdata   = val_q;
				cnt_d   = cnt_q + CW'(1);
				state_d = FSM_FINISH;
			end
			FSM_FINISH: begin
				if (res_ready) begin
					res_valid = 1'b1;
					state_d   = FSM_IDLE;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FSM_IDLE;
			cnt_q   <= '0;
			rv_s1   <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			rv_s1   <= issue;
		end
	end

	always_ff @(posedge clk) begin
		cmd_q   <= cmd_d;
		pos_q   <= pos_d;
		val_q   <= val_d;
		idx_q   <= idx_d;
		ridx_s1 <= raddr;
		rd_q    <= rd_d;
		fpos_q  <= fpos_d;
		fnd_q   <= fnd_d;
		st_q    <= st_d;
	end

	assign res.read_value     = rd_q;
	assign res.found_position = fpos_q;
	assign res.found          = fnd_q;
	assign res.count          = CNT_OUT_W'(cnt_q);
	assign res.empty_res      = cnt_q == '0;
	assign res.status         = st_q;

endmodule

// ===== rtl/core/indexed_list_engine.sv =====
// ----------------------------------------------------------------------------
// indexed_list_engine
// ordered list of up to CAPACITY values with get, set, insert, remove,
// append, search and clear commands over one entry ram
// ----------------------------------------------------------------------------
//  channel | direction | transaction
//  s_*     | in        | one command: command, position, entry_value
//  m_*     | out       | one result per command: value, search result, count,
//          |           | empty flag and status
//
//  set, append, clear, refused commands and a remove of the last entry
//  finish without a scan of the entry ram; get waits on one ram read;
//  insert moves the entries from the top down to its position, remove_at
//  the entries behind its position; a search compares entries from the
//  first until a match or the last, and a remove_value that closes a gap
//  then moves the entries behind the match; the single read port of the
//  entry ram paces every scan at one entry a cycle
//  reset clears the count and the output valid flag at once; the entry ram has
//  no reset, since only entries below the count are ever read
//  a new command is taken while the last result still waits on m_tready; the
//  sequencer then holds its result until the output register frees up
// ----------------------------------------------------------------------------
module indexed_list_engine #(
	parameter int CAPACITY    = 16,
	parameter int VALUE_WIDTH = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// command [2:0], position [6:3], entry_value [38:7], zero [39]
	input  logic [ile_pkg::S_TDATA_W-1:0]  s_tdata,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// read_value [31:0], found_position [35:32], found [36], count [41:37],
	// empty_res [42], status [44:43], zero [47:45]
	output logic [ile_pkg::M_TDATA_W-1:0]  m_tdata
);

	import ile_pkg::*;

	localparam int AW = $clog2(CAPACITY);

	cmd_req_t               req;
	res_t                   res, res_q;
	logic                   res_valid, res_ready, m_tvalid_q;
	logic                   ram_we;
	logic [AW-1:0]          ram_waddr, ram_raddr;
	logic [VALUE_WIDTH-1:0] ram_wdata, ram_rdata;

	// unpack the command transaction
	assign req.command     = cmd_t'(s_tdata[2:0]);
	assign req.position    = s_tdata[6:3];
	assign req.entry_value = s_tdata[38:7];

	// output register can take a result when empty or draining this cycle
	assign res_ready = !m_tvalid_q || m_tready;

	ile_ctrl #(
		.CAPACITY    (CAPACITY),
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (s_tvalid),
		.cmd_ready (s_tready),
		.req       (req),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.we        (ram_we),
		.waddr     (ram_waddr),
		.wdata     (ram_wdata),
		.raddr     (ram_raddr),
		.rdata     (ram_rdata)
	);

	// entry store, one write and one read a cycle
	ile_ram #(
		.WIDTH (VALUE_WIDTH),
		.DEPTH (CAPACITY)
	) u_entries (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// result output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_valid) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			res_q <= res;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {3'b000, res_q.status, res_q.empty_res, res_q.count,
		res_q.found, res_q.found_position, res_q.read_value};

endmodule

// ===== rtl/core/ile_chk.sv =====
// ----------------------------------------------------------------------------
// ile_chk
// port-level checks on the result stream of the list engine
// ----------------------------------------------------------------------------
`include "indexed_list_engine_assert.svh"

module ile_chk #(
	parameter int CAPACITY = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          m_tvalid,
	input  logic                          m_tready,
	input  logic [ile_pkg::M_TDATA_W-1:0] m_tdata
);

	import ile_pkg::*;

	// a stalled result stays put
	`ILE_ASSERT_NXT(a_res_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")

	// a match always reports success
	`ILE_ASSERT_IMP(a_found_ok, m_tvalid && m_tdata[36], m_tdata[44:43] == ST_OK, "found with bad status")

	// a failed search reports no position
	`ILE_ASSERT_IMP(a_miss_clean, m_tvalid && m_tdata[44:43] == ST_NOTFOUND, !m_tdata[36] && m_tdata[35:32] == 4'd0, "miss with search result")

	// count never passes capacity
	`ILE_ASSERT_IMP(a_count_cap, m_tvalid, m_tdata[41:37] <= CAPACITY, "count above capacity")

endmodule

bind indexed_list_engine ile_chk #(
	.CAPACITY (CAPACITY)
) u_ile_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

// ===== bench/indexed_list_engine_tb.sv =====
// ----------------------------------------------------------------------------
// indexed_list_engine_tb
// self-checking bench for the indexed list engine: directed commands on an
// empty, a partly filled and a full list, then random command traffic with
// an in-bench list model predicting every result, random idling on both sides
// ----------------------------------------------------------------------------
module indexed_list_engine_tb;

	import ile_pkg::*;

	localparam int LIST_DEPTH   = 16;
	localparam int RANDOM_ITEMS = 600;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int DRAIN_CYCLES = 2 * LIST_DEPTH + 8;
	localparam int MAX_REPORTS  = 10;

	// clock and reset
	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	// slave side: command transactions
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	// command [2:0], position [6:3], entry_value [38:7], zero [39]
	logic [S_TDATA_W-1:0] s_tdata  = '0;

	// master side: result transactions
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	// read_value [31:0], found_position [35:32], found [36], count [41:37],
	// empty_res [42], status [44:43], zero [47:45]
	logic [M_TDATA_W-1:0] m_tdata;

	// list model held by the bench
	logic [DATA_W-1:0] list_entries [LIST_DEPTH];
	int                list_count = 0;
	int                peak_count = 0;

	// results still owed by the block, oldest first
	res_t pending_results [$];

	// values that recur so that searches hit, duplicates included
	logic [DATA_W-1:0] value_pool [8];

	// bookkeeping
	bit  no_gaps         = 1'b0;
	int  items_sent      = 0;
	int  results_checked = 0;
	int  mismatches      = 0;
	int  cycle_count     = 0;
	int  status_seen [4] = '{0, 0, 0, 0};

	indexed_list_engine #(
		.CAPACITY    (LIST_DEPTH),
		.VALUE_WIDTH (DATA_W)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// list model
	// ------------------------------------------------------------------

	// close the gap left at one position
	function automatic void drop_entry(int at);
		for (int i = at; i + 1 < list_count; i++)
			list_entries[i] = list_entries[i + 1];
		list_count--;
	endfunction

	// apply one command to the model and return the result it owes
	function automatic res_t predict_result(cmd_t op, logic [POS_W-1:0] pos,
			logic [DATA_W-1:0] val);
		res_t r;
		bit   in_range;
		int   hit;
		r        = '0;
		r.status = ST_OK;
		in_range = int'(pos) < list_count;
		hit      = -1;
		case (op) inside
			CMD_GET: begin
				if (in_range) r.read_value = list_entries[pos];
				else r.status = ST_RANGE;
			end
			CMD_SET: begin
				if (in_range) list_entries[pos] = val;
				else r.status = ST_RANGE;
			end
			CMD_INSERT: begin
				// the position check wins over the full check
				if (!in_range) begin
					r.status = ST_RANGE;
				end else if (list_count >= LIST_DEPTH) begin
					r.status = ST_FULL;
				end else begin
					for (int i = list_count; i > int'(pos); i--)
						list_entries[i] = list_entries[i - 1];
					list_entries[pos] = val;
					list_count++;
				end
			end
			CMD_REMOVE_AT: begin
				if (in_range) drop_entry(int'(pos));
				else r.status = ST_RANGE;
			end
			CMD_APPEND: begin
				if (list_count >= LIST_DEPTH) begin
					r.status = ST_FULL;
				end else begin
					list_entries[list_count] = val;
					list_count++;
				end
			end
			CMD_REMOVE_VALUE, CMD_INDEX_OF: begin
				// first match only
				for (int i = 0; i < list_count; i++)
					if (hit < 0 && list_entries[i] == val) hit = i;
				if (hit >= 0) begin
					r.found          = 1'b1;
					r.found_position = POS_W'(hit);
					if (op == CMD_REMOVE_VALUE) drop_entry(hit);
				end else begin
					r.status = ST_NOTFOUND;
				end
			end
			default: begin
				list_count = 0;
			end
		endcase
		r.count     = CNT_OUT_W'(list_count);
		r.empty_res = (list_count == 0);
		if (list_count > peak_count) peak_count = list_count;
		return r;
	endfunction

	// ------------------------------------------------------------------
	// command side
	// ------------------------------------------------------------------

	// one command transaction, with a random hold-off in front of it outside the no-gap stretch
	task automatic issue_command(cmd_t op, logic [POS_W-1:0] pos, logic [DATA_W-1:0] val);
		if (!no_gaps) begin
			while ($urandom_range(99) < 12) begin
				s_tvalid <= 1'b0;
				@(posedge clk);
			end
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {1'b0, val, pos, op};
		do @(posedge clk); while (!s_tready);
		pending_results.push_back(predict_result(op, pos, val));
		items_sent++;
	endtask

	// ------------------------------------------------------------------
	// result side
	// ------------------------------------------------------------------

	// sink stalls about one cycle in eight, never inside the no-gap stretch
	always @(posedge clk) begin
		if (no_gaps) m_tready <= 1'b1;
		else m_tready <= ($urandom_range(99) >= 12);
	end

	function automatic void compare_field(string name, logic [DATA_W-1:0] want,
			logic [DATA_W-1:0] got);
		if (want !== got) begin
			mismatches++;
			if (mismatches <= MAX_REPORTS)
				$display("mismatch in %s of result %0d: expected %0h, got %0h",
					name, results_checked, want, got);
		end
	endfunction

	always @(posedge clk) begin : result_check
		res_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("result %0d arrived with nothing expected: %0h",
						results_checked, m_tdata);
			end else begin
				want = pending_results.pop_front();
				compare_field("read_value", want.read_value, m_tdata[31:0]);
				compare_field("found_position", DATA_W'(want.found_position),
					DATA_W'(m_tdata[35:32]));
				compare_field("found", DATA_W'(want.found), DATA_W'(m_tdata[36]));
				compare_field("count", DATA_W'(want.count), DATA_W'(m_tdata[41:37]));
				compare_field("empty_res", DATA_W'(want.empty_res),
					DATA_W'(m_tdata[42]));
				compare_field("status", DATA_W'(want.status), DATA_W'(m_tdata[44:43]));
				status_seen[int'(want.status)]++;
			end
			results_checked++;
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("run stopped after %0d cycles, %0d results still owed",
				cycle_count, pending_results.size());
			$display("indexed_list_engine verification failed");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------

	// every positional command refused, searches miss, clear on nothing
	task automatic test_empty_list();
		issue_command(CMD_GET, 4'd0, '0);
		issue_command(CMD_SET, 4'd15, 32'hffff_ffff);
		issue_command(CMD_INSERT, 4'd0, 32'h1234_5678);
		issue_command(CMD_REMOVE_AT, 4'd0, '0);
		issue_command(CMD_INDEX_OF, 4'd0, '0);
		issue_command(CMD_REMOVE_VALUE, 4'd0, 32'hffff_ffff);
		issue_command(CMD_CLEAR, 4'd0, '0);
	endtask

	// shifts both ways, first match among duplicates, end position refused
	task automatic test_edit_and_search();
		issue_command(CMD_APPEND, 4'd0, 32'h0000_0000);
		issue_command(CMD_APPEND, 4'd0, 32'hffff_ffff);
		issue_command(CMD_APPEND, 4'd0, 32'h5a5a_a5a5);
		issue_command(CMD_INSERT, 4'd0, 32'hdead_beef);
		issue_command(CMD_INSERT, 4'd4, 32'h0bad_cafe);   // end position
		issue_command(CMD_INSERT, 4'd2, 32'hffff_ffff);
		issue_command(CMD_GET, 4'd4, '0);
		issue_command(CMD_GET, 4'd5, '0);
		issue_command(CMD_SET, 4'd4, 32'h0000_0001);
		issue_command(CMD_INDEX_OF, 4'd0, 32'hffff_ffff);
		issue_command(CMD_REMOVE_VALUE, 4'd0, 32'hffff_ffff);
		issue_command(CMD_INDEX_OF, 4'd0, 32'h1234_5678);
		issue_command(CMD_REMOVE_AT, 4'd0, '0);
		issue_command(CMD_REMOVE_AT, 4'd3, '0);
	endtask

	// fill to the brim, refusals when full, work on the last entry
	task automatic test_full_list();
		issue_command(CMD_CLEAR, 4'd9, '0);
		for (int i = 0; i < LIST_DEPTH; i++)
			issue_command(CMD_APPEND, 4'(i), (i == 0) ? 32'h8000_0000 : $urandom);
		issue_command(CMD_APPEND, 4'd0, 32'h7fff_ffff);
		issue_command(CMD_INSERT, 4'd7, 32'h7fff_ffff);
		issue_command(CMD_GET, 4'd15, '0);
		issue_command(CMD_INDEX_OF, 4'd0, list_entries[LIST_DEPTH - 1]);
		issue_command(CMD_REMOVE_AT, 4'd15, '0);
		issue_command(CMD_INSERT, 4'd0, 32'h8000_0000);
		issue_command(CMD_REMOVE_VALUE, 4'd0, 32'h8000_0000);
		issue_command(CMD_CLEAR, 4'd0, '0);
	endtask

	// random traffic in growing, shrinking and mixed moods
	task automatic test_random_traffic(int n);
		int                mood;
		int                pick;
		cmd_t              op;
		logic [POS_W-1:0]  pos;
		logic [DATA_W-1:0] val;
		mood = 0;
		for (int k = 0; k < n; k++) begin
			// a long stretch with no idling on either side
			if (k == n / 3) no_gaps <= 1'b1;
			if (k == n / 2) no_gaps <= 1'b0;
			if ($urandom_range(39) == 0) mood = $urandom_range(2);

			pick = $urandom_range(99);
			case (mood)
				0: op = (pick < 35) ? CMD_APPEND : (pick < 65) ? CMD_INSERT :
					(pick < 75) ? CMD_SET : (pick < 85) ? CMD_GET :
					(pick < 90) ? CMD_INDEX_OF : (pick < 95) ? CMD_REMOVE_AT :
					(pick < 98) ? CMD_REMOVE_VALUE : CMD_CLEAR;
				1: op = (pick < 30) ? CMD_REMOVE_AT : (pick < 55) ? CMD_REMOVE_VALUE :
					(pick < 70) ? CMD_INDEX_OF : (pick < 85) ? CMD_GET :
					(pick < 93) ? CMD_SET : (pick < 98) ? CMD_APPEND : CMD_CLEAR;
				default: op = (pick < 3) ? CMD_CLEAR : cmd_t'($urandom_range(6));
			endcase

			// mostly live positions, now and then anything the field holds
			if (list_count > 0 && $urandom_range(99) < 85)
				pos = POS_W'($urandom_range(list_count - 1));
			else
				pos = POS_W'($urandom_range(15));

			// live values make searches hit, the pool makes duplicates
			pick = $urandom_range(99);
			if (pick < 30 && list_count > 0)
				val = list_entries[$urandom_range(list_count - 1)];
			else if (pick < 60)
				val = value_pool[$urandom_range(7)];
			else
				val = $urandom;

			issue_command(op, pos, val);
		end
	endtask

	// ------------------------------------------------------------------
	// sequence
	// ------------------------------------------------------------------
	initial begin
		value_pool[0] = 32'h0000_0000;
		value_pool[1] = 32'hffff_ffff;
		value_pool[2] = 32'h8000_0000;
		value_pool[3] = 32'h0000_0001;
		for (int i = 4; i < 8; i++)
			value_pool[i] = $urandom;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_list();
		test_edit_and_search();
		test_full_list();
		test_random_traffic(RANDOM_ITEMS);
		s_tvalid <= 1'b0;

		// drain, then give the block a few more cycles to misbehave
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d commands and %0d results, fill reaching %0d of %0d",
			items_sent, results_checked, peak_count, LIST_DEPTH);
		$display("statuses: ok %0d, bad position %0d, full %0d, not found %0d",
			status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
		if (mismatches == 0 && pending_results.size() == 0)
			$display("indexed_list_engine verification clean");
		else
			$display("indexed_list_engine verification failed");
		$finish;
	end

endmodule
